/* rtl/kcc_pkg.sv */
`timescale 1ns / 1ps
package kcc_pkg;

  // defaults for the top level parameters
  localparam int CLUSTERS_DEF  = 3;
  localparam int DIMENSION_DEF = 64;

  // field widths
  localparam int POINT_W  = 64;
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 2;
  localparam int ID_W     = 2;
  localparam int SHIFT_W  = 21;
  localparam int DIM_W    = 7;
  localparam int CFG_W    = 21;
  localparam int CFG_IDX_W = 1;

  // datapath widths, sized for the largest dimension
  localparam int VAL_W   = 17;
  localparam int DOT_W   = 23;
  localparam int DSQ_W   = 46;
  localparam int NORM_W  = 39;
  localparam int PROD_W  = 85;
  localparam int SQ_W    = 40;
  localparam int DIVD_W  = 34;
  localparam int ROOT_W  = 20;
  localparam int IT_W    = 6;
  localparam int C_MAX_W = 4;
  localparam int J_MAX_W = 6;

  localparam logic [VAL_W-1:0]   ONE_Q16   = 17'd65536;
  localparam logic [VAL_W-1:0]   ACC_MAX   = 17'd131071;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 21'd2097151;
  localparam logic [SHIFT_W-1:0] THRESHOLD_RESET = 21'd655;
  localparam logic [DIM_W-1:0]   DIMENSION_RESET = 7'd64;

  // actions
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ASSIGN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_END    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 1'd1;

  // datapath operations
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_ACCEPT     = 5'd1;
  localparam logic [4:0] OP_CLEAR      = 5'd2;
  localparam logic [4:0] OP_LOAD       = 5'd3;
  localparam logic [4:0] OP_LOAD_FIN   = 5'd4;
  localparam logic [4:0] OP_DOT_RD     = 5'd5;
  localparam logic [4:0] OP_DOT_TAIL   = 5'd6;
  localparam logic [4:0] OP_SQ         = 5'd7;
  localparam logic [4:0] OP_MUL_START  = 5'd8;
  localparam logic [4:0] OP_MUL        = 5'd9;
  localparam logic [4:0] OP_TAKE       = 5'd10;
  localparam logic [4:0] OP_ACC_RD     = 5'd11;
  localparam logic [4:0] OP_ACC_TAIL   = 5'd12;
  localparam logic [4:0] OP_END_RD     = 5'd13;
  localparam logic [4:0] OP_DIV_START  = 5'd14;
  localparam logic [4:0] OP_DIV        = 5'd15;
  localparam logic [4:0] OP_END_WR     = 5'd16;
  localparam logic [4:0] OP_SQRT_START = 5'd17;
  localparam logic [4:0] OP_SQRT       = 5'd18;
  localparam logic [4:0] OP_SQRT_FIN   = 5'd19;
  localparam logic [4:0] OP_END_FIN    = 5'd20;
  localparam logic [4:0] OP_RESULT     = 5'd21;

  typedef struct packed {
    logic [4:0]         op;
    logic [C_MAX_W-1:0] c;
    logic [J_MAX_W-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic cand;
    logic have;
    logic gt;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic cnt_zero;
    logic out_free;
  } stat_t;

endpackage

/* rtl/kcc_in_if.sv */
`timescale 1ns / 1ps
interface kcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [kcc_pkg::ACTION_W-1:0]  action;
  logic [kcc_pkg::SLOT_W-1:0]    slot_index;
  logic [kcc_pkg::POINT_W-1:0]   point_bits;
  modport source (output valid, action, slot_index, point_bits, input ready);
  modport sink (input valid, action, slot_index, point_bits, output ready);
endinterface

/* rtl/kcc_out_if.sv */
`timescale 1ns / 1ps
interface kcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [kcc_pkg::ID_W-1:0]     cluster_id;
  logic [kcc_pkg::SHIFT_W-1:0]  total_shift;
  logic                         converged;
  modport source (output valid, cluster_id, total_shift, converged, input ready);
  modport sink (input valid, cluster_id, total_shift, converged, output ready);
endinterface

/* rtl/kcc_datapath.sv */
`timescale 1ns / 1ps
module kcc_datapath #(
  parameter int CLUSTERS  = kcc_pkg::CLUSTERS_DEF,
  parameter int DIMENSION = kcc_pkg::DIMENSION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kcc_pkg::cmd_t                 cmd,
  output kcc_pkg::stat_t                stat,
  input  logic [kcc_pkg::SHIFT_W-1:0]   threshold,
  input  logic [kcc_pkg::DIM_W-1:0]     dim,
  input  logic [kcc_pkg::ACTION_W-1:0]  in_action,
  input  logic [kcc_pkg::POINT_W-1:0]   in_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kcc_pkg::ID_W-1:0]      out_cluster_id,
  output logic [kcc_pkg::SHIFT_W-1:0]   out_total_shift,
  output logic                          out_converged
);
  localparam int DEPTH = CLUSTERS * DIMENSION;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(CLUSTERS);
  localparam int JW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
  localparam int JM = kcc_pkg::J_MAX_W;
  localparam int VW = kcc_pkg::VAL_W;

  logic [VW-1:0] cent_mem [DEPTH];
  logic [VW-1:0] sum_mem [DEPTH];
  logic [VW-1:0] cent_rd, sum_rd;

  logic [kcc_pkg::POINT_W-1:0] bits_q;
  logic [kcc_pkg::ACTION_W-1:0] act_q;
  logic [AW-1:0] addr, addr_q;
  logic [JW-1:0] j, jq;
  logic [CW-1:0] c_sel, idx, best;
  logic rd_dot_q, rd_acc_q;

  logic [VW-1:0] counts [CLUSTERS];
  logic [kcc_pkg::NORM_W-1:0] norms [CLUSTERS];
  logic [VW-1:0] count_sel;
  logic [kcc_pkg::NORM_W-1:0] norm_sel;

  logic [kcc_pkg::DOT_W-1:0] dot, best_dot;
  logic [kcc_pkg::NORM_W-1:0] best_norm, nacc;
  logic have;
  logic [kcc_pkg::DSQ_W-1:0] dsq, bsq;
  logic [kcc_pkg::PROD_W-1:0] p1, p2, a1, a2;
  logic [kcc_pkg::NORM_W-1:0] b1, b2;
  logic [kcc_pkg::IT_W-1:0] it;

  logic [kcc_pkg::DIVD_W-1:0] dvd;
  logic [VW-1:0] rem;
  logic [VW:0] trial;

  logic [kcc_pkg::SQ_W-1:0] sq, sv, res, bitv, rb;
  logic [kcc_pkg::SHIFT_W-1:0] total;
  logic [kcc_pkg::SHIFT_W:0] total_sum;

  logic [VW-1:0] nv, diff;
  logic [kcc_pkg::DIM_W-1:0] d_eff;
  logic [kcc_pkg::POINT_W-1:0] mask;
  logic rd_en, bit_now, bit_q, cent_we, sum_we, acc_wr, use_best;
  logic [AW-1:0] cent_wa, sum_wa;
  logic [VW-1:0] cent_wd, sum_wd;

  assign c_sel    = cmd.c[CW-1:0];
  assign j        = cmd.j[JW-1:0];
  assign use_best = (cmd.op == kcc_pkg::OP_ACC_RD) || (cmd.op == kcc_pkg::OP_ACC_TAIL);
  assign idx      = use_best ? best : c_sel;
  assign addr     = AW'(idx) * AW'(DIMENSION) + AW'(j);
  assign count_sel = counts[idx];
  assign norm_sel  = norms[idx];
  assign bit_now  = bits_q[JM'(j)];
  assign bit_q    = bits_q[JM'(jq)];

  // effective feature count and mask
  always_comb begin
    if (dim == '0) d_eff = kcc_pkg::DIM_W'(1);
    else if (dim > kcc_pkg::DIM_W'(DIMENSION)) d_eff = kcc_pkg::DIM_W'(DIMENSION);
    else d_eff = dim;
    if (d_eff >= kcc_pkg::DIM_W'(kcc_pkg::POINT_W)) mask = '1;
    else mask = (kcc_pkg::POINT_W'(1) << d_eff) - kcc_pkg::POINT_W'(1);
  end

  // new centroid component and its move
  always_comb begin
    if (dvd > kcc_pkg::DIVD_W'(kcc_pkg::ONE_Q16)) nv = kcc_pkg::ONE_Q16;
    else nv = dvd[VW-1:0];
    diff = (nv >= cent_rd) ? (nv - cent_rd) : (cent_rd - nv);
    trial = {rem, dvd[kcc_pkg::DIVD_W-1]};
    rb = res + bitv;
    total_sum = {1'b0, total} + (kcc_pkg::SHIFT_W + 1)'(res[kcc_pkg::ROOT_W-1:0]);
  end

  // memory port control
  always_comb begin
    rd_en = (cmd.op == kcc_pkg::OP_DOT_RD) || (cmd.op == kcc_pkg::OP_ACC_RD) ||
            (cmd.op == kcc_pkg::OP_END_RD);
    acc_wr = rd_acc_q && bit_q && (sum_rd < kcc_pkg::ACC_MAX) &&
             (count_sel < kcc_pkg::ACC_MAX);
    cent_we = (cmd.op == kcc_pkg::OP_CLEAR) || (cmd.op == kcc_pkg::OP_LOAD) ||
              (cmd.op == kcc_pkg::OP_END_WR);
    cent_wa = (cmd.op == kcc_pkg::OP_END_WR) ? addr_q : addr;
    case (cmd.op)
      kcc_pkg::OP_LOAD:   cent_wd = bit_now ? kcc_pkg::ONE_Q16 : '0;
      kcc_pkg::OP_END_WR: cent_wd = nv;
      default:            cent_wd = '0;
    endcase
    sum_we = (cmd.op == kcc_pkg::OP_CLEAR) || (cmd.op == kcc_pkg::OP_END_WR) || acc_wr;
    sum_wa = (cmd.op == kcc_pkg::OP_CLEAR) ? addr : addr_q;
    sum_wd = acc_wr ? (sum_rd + VW'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (cent_we) cent_mem[cent_wa] <= cent_wd;
    if (rd_en) cent_rd <= cent_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (rd_en) sum_rd <= sum_mem[addr];
  end

  // control state: read pipeline flags, counts, norms, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_dot_q  <= 1'b0;
      rd_acc_q  <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < CLUSTERS; k++) begin
        counts[k] <= '0;
        norms[k]  <= '0;
      end
    end else begin
      rd_dot_q <= (cmd.op == kcc_pkg::OP_DOT_RD);
      rd_acc_q <= (cmd.op == kcc_pkg::OP_ACC_RD);
      if (cmd.op == kcc_pkg::OP_ACCEPT) have <= 1'b0;
      else if (cmd.op == kcc_pkg::OP_TAKE) have <= 1'b1;
      if (cmd.op == kcc_pkg::OP_ACC_TAIL && count_sel < kcc_pkg::ACC_MAX) begin
        counts[idx] <= count_sel + VW'(1);
      end
      if (cmd.op == kcc_pkg::OP_END_FIN) begin
        for (int k = 0; k < CLUSTERS; k++) counts[k] <= '0;
      end
      if (cmd.op == kcc_pkg::OP_LOAD_FIN || cmd.op == kcc_pkg::OP_SQRT_FIN) begin
        norms[idx] <= nacc;
      end
      if (cmd.op == kcc_pkg::OP_RESULT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_q <= addr;
    jq     <= j;
    if (rd_dot_q && bit_q) dot <= dot + kcc_pkg::DOT_W'(cent_rd);
    case (cmd.op)
      kcc_pkg::OP_ACCEPT: begin
        bits_q <= in_bits & mask;
        act_q  <= in_action;
        best   <= '0;
        total  <= '0;
      end
      kcc_pkg::OP_LOAD: begin
        nacc <= ((j == '0) ? '0 : nacc) +
                (bit_now ? (kcc_pkg::NORM_W'(1) << 32) : '0);
      end
      kcc_pkg::OP_DOT_RD: begin
        if (j == '0) dot <= '0;
      end
      kcc_pkg::OP_SQ: begin
        dsq <= kcc_pkg::DSQ_W'(dot) * kcc_pkg::DSQ_W'(dot);
        bsq <= kcc_pkg::DSQ_W'(best_dot) * kcc_pkg::DSQ_W'(best_dot);
      end
      kcc_pkg::OP_MUL_START: begin
        p1 <= '0;
        p2 <= '0;
        a1 <= kcc_pkg::PROD_W'(dsq);
        a2 <= kcc_pkg::PROD_W'(bsq);
        b1 <= best_norm;
        b2 <= norm_sel;
        it <= '0;
      end
      kcc_pkg::OP_MUL: begin
        if (b1[0]) p1 <= p1 + a1;
        if (b2[0]) p2 <= p2 + a2;
        a1 <= a1 << 1;
        a2 <= a2 << 1;
        b1 <= b1 >> 1;
        b2 <= b2 >> 1;
        it <= it + kcc_pkg::IT_W'(1);
      end
      kcc_pkg::OP_TAKE: begin
        best      <= c_sel;
        best_dot  <= dot;
        best_norm <= norm_sel;
      end
      kcc_pkg::OP_DIV_START: begin
        dvd <= {sum_rd, 16'd0} + kcc_pkg::DIVD_W'(count_sel >> 1);
        rem <= '0;
        it  <= '0;
      end
      kcc_pkg::OP_DIV: begin
        if (trial >= {1'b0, count_sel}) begin
          rem <= VW'(trial - {1'b0, count_sel});
          dvd <= {dvd[kcc_pkg::DIVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[VW-1:0];
          dvd <= {dvd[kcc_pkg::DIVD_W-2:0], 1'b0};
        end
        it <= it + kcc_pkg::IT_W'(1);
      end
      kcc_pkg::OP_END_WR: begin
        sq   <= ((j == '0) ? '0 : sq) +
                kcc_pkg::SQ_W'(kcc_pkg::SQ_W'(diff) * kcc_pkg::SQ_W'(diff));
        nacc <= ((j == '0) ? '0 : nacc) +
                kcc_pkg::NORM_W'(kcc_pkg::NORM_W'(nv) * kcc_pkg::NORM_W'(nv));
      end
      kcc_pkg::OP_SQRT_START: begin
        sv   <= sq;
        res  <= '0;
        bitv <= kcc_pkg::SQ_W'(1) << (kcc_pkg::SQ_W - 2);
        it   <= '0;
      end
      kcc_pkg::OP_SQRT: begin
        if (sv >= rb) begin
          sv  <= sv - rb;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        it   <= it + kcc_pkg::IT_W'(1);
      end
      kcc_pkg::OP_SQRT_FIN: begin
        total <= (total_sum > {1'b0, kcc_pkg::SHIFT_MAX}) ? kcc_pkg::SHIFT_MAX
                                                          : total_sum[kcc_pkg::SHIFT_W-1:0];
      end
      kcc_pkg::OP_RESULT: begin
        out_cluster_id  <= (act_q == kcc_pkg::ACT_ASSIGN) ? kcc_pkg::ID_W'(best) : '0;
        out_total_shift <= (act_q == kcc_pkg::ACT_END) ? total : '0;
        out_converged   <= (act_q == kcc_pkg::ACT_END) && (total <= threshold);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.cand      = (dot != '0) && (norm_sel != '0);
    stat.have      = have;
    stat.gt        = p1 > p2;
    stat.mul_done  = it == kcc_pkg::IT_W'(kcc_pkg::NORM_W - 1);
    stat.div_done  = it == kcc_pkg::IT_W'(kcc_pkg::DIVD_W - 1);
    stat.sqrt_done = it == kcc_pkg::IT_W'(kcc_pkg::ROOT_W - 1);
    stat.cnt_zero  = count_sel == '0;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

/* rtl/kcc_controller.sv */
`timescale 1ns / 1ps
module kcc_controller #(
  parameter int CLUSTERS  = kcc_pkg::CLUSTERS_DEF,
  parameter int DIMENSION = kcc_pkg::DIMENSION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kcc_pkg::ACTION_W-1:0]  in_action,
  input  logic [kcc_pkg::SLOT_W-1:0]    in_slot,
  output kcc_pkg::cmd_t                 cmd,
  input  kcc_pkg::stat_t                stat
);
  localparam int CW = $clog2(CLUSTERS);
  localparam int JW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

  localparam logic [4:0] ST_CLEAR      = 5'd0;
  localparam logic [4:0] ST_IDLE       = 5'd1;
  localparam logic [4:0] ST_LOAD       = 5'd2;
  localparam logic [4:0] ST_LOAD_FIN   = 5'd3;
  localparam logic [4:0] ST_DOT        = 5'd4;
  localparam logic [4:0] ST_DOT_TAIL   = 5'd5;
  localparam logic [4:0] ST_SQ         = 5'd6;
  localparam logic [4:0] ST_MUL_START  = 5'd7;
  localparam logic [4:0] ST_MUL        = 5'd8;
  localparam logic [4:0] ST_DECIDE     = 5'd9;
  localparam logic [4:0] ST_ACC        = 5'd10;
  localparam logic [4:0] ST_ACC_TAIL   = 5'd11;
  localparam logic [4:0] ST_END_CL     = 5'd12;
  localparam logic [4:0] ST_END_RD     = 5'd13;
  localparam logic [4:0] ST_DIV_START  = 5'd14;
  localparam logic [4:0] ST_DIV        = 5'd15;
  localparam logic [4:0] ST_END_WR     = 5'd16;
  localparam logic [4:0] ST_SQRT_START = 5'd17;
  localparam logic [4:0] ST_SQRT       = 5'd18;
  localparam logic [4:0] ST_SQRT_FIN   = 5'd19;
  localparam logic [4:0] ST_END_FIN    = 5'd20;
  localparam logic [4:0] ST_RESULT     = 5'd21;

  logic [4:0] state, state_next;
  logic [CW-1:0] c, c_next;
  logic [JW-1:0] j, j_next;
  logic c_last, j_last;

  assign c_last = c == CW'(CLUSTERS - 1);
  assign j_last = j == JW'(DIMENSION - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      c     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      c     <= c_next;
      j     <= j_next;
    end
  end

  always_comb begin
    state_next = state;
    c_next     = c;
    j_next     = j;
    in_ready   = 1'b0;
    cmd.op     = kcc_pkg::OP_NONE;
    cmd.c      = kcc_pkg::C_MAX_W'(c);
    cmd.j      = kcc_pkg::J_MAX_W'(j);
    case (state)
      ST_CLEAR: begin
        cmd.op = kcc_pkg::OP_CLEAR;
        j_next = j + JW'(1);
        if (j_last) begin
          j_next = '0;
          c_next = c + CW'(1);
          if (c_last) begin
            c_next     = '0;
            state_next = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = kcc_pkg::OP_ACCEPT;
          c_next = '0;
          j_next = '0;
          case (in_action)
            kcc_pkg::ACT_LOAD: begin
              if (int'(in_slot) < CLUSTERS) begin
                c_next     = CW'(in_slot);
                state_next = ST_LOAD;
              end else begin
                state_next = ST_RESULT;
              end
            end
            kcc_pkg::ACT_ASSIGN: state_next = ST_DOT;
            kcc_pkg::ACT_END:    state_next = ST_END_CL;
            default:             state_next = ST_RESULT;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.op = kcc_pkg::OP_LOAD;
        j_next = j + JW'(1);
        if (j_last) begin
          j_next     = '0;
          state_next = ST_LOAD_FIN;
        end
      end
      ST_LOAD_FIN: begin
        cmd.op     = kcc_pkg::OP_LOAD_FIN;
        state_next = ST_RESULT;
      end
      ST_DOT: begin
        cmd.op = kcc_pkg::OP_DOT_RD;
        j_next = j + JW'(1);
        if (j_last) begin
          j_next     = '0;
          state_next = ST_DOT_TAIL;
        end
      end
      ST_DOT_TAIL: begin
        cmd.op     = kcc_pkg::OP_DOT_TAIL;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = kcc_pkg::OP_SQ;
        if (stat.cand && !stat.have) begin
          state_next = ST_DECIDE;
        end else if (stat.cand) begin
          state_next = ST_MUL_START;
        end else if (c_last) begin
          state_next = ST_ACC;
        end else begin
          c_next     = c + CW'(1);
          state_next = ST_DOT;
        end
      end
      ST_MUL_START: begin
        cmd.op     = kcc_pkg::OP_MUL_START;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = kcc_pkg::OP_MUL;
        if (stat.mul_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        // first candidate is taken outright, later ones only when strictly better
        if (!stat.have || stat.gt) cmd.op = kcc_pkg::OP_TAKE;
        if (c_last) begin
          state_next = ST_ACC;
        end else begin
          c_next     = c + CW'(1);
          state_next = ST_DOT;
        end
      end
      ST_ACC: begin
        cmd.op = kcc_pkg::OP_ACC_RD;
        j_next = j + JW'(1);
        if (j_last) begin
          j_next     = '0;
          state_next = ST_ACC_TAIL;
        end
      end
      ST_ACC_TAIL: begin
        cmd.op     = kcc_pkg::OP_ACC_TAIL;
        state_next = ST_RESULT;
      end
      ST_END_CL: begin
        j_next = '0;
        if (!stat.cnt_zero) begin
          state_next = ST_END_RD;
        end else if (c_last) begin
          state_next = ST_END_FIN;
        end else begin
          c_next = c + CW'(1);
        end
      end
      ST_END_RD: begin
        cmd.op     = kcc_pkg::OP_END_RD;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.op     = kcc_pkg::OP_DIV_START;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = kcc_pkg::OP_DIV;
        if (stat.div_done) state_next = ST_END_WR;
      end
      ST_END_WR: begin
        cmd.op = kcc_pkg::OP_END_WR;
        j_next = j + JW'(1);
        state_next = ST_END_RD;
        if (j_last) begin
          j_next     = '0;
          state_next = ST_SQRT_START;
        end
      end
      ST_SQRT_START: begin
        cmd.op     = kcc_pkg::OP_SQRT_START;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = kcc_pkg::OP_SQRT;
        if (stat.sqrt_done) state_next = ST_SQRT_FIN;
      end
      ST_SQRT_FIN: begin
        cmd.op = kcc_pkg::OP_SQRT_FIN;
        if (c_last) begin
          state_next = ST_END_FIN;
        end else begin
          c_next     = c + CW'(1);
          state_next = ST_END_CL;
        end
      end
      ST_END_FIN: begin
        cmd.op     = kcc_pkg::OP_END_FIN;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.op     = kcc_pkg::OP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/kmeans_cosine_cluster_engine.sv */
`timescale 1ns / 1ps
// work per transaction (C clusters, D dimensions): load sweeps D elements; a bad slot or
//   unknown action goes straight to the result, assign sweeps D elements per cluster,
//   compares later candidates, then accumulates; end pass recenters non-empty clusters
// paced by single-port element sweeps and the bit-serial multiplier (39 steps), divider
//   (34 steps) and square root (20 steps); one transaction at a time, plus output stalls
// reset: synchronous, active high; then a C*D element clearing pass with input ready low
module kmeans_cosine_cluster_engine #(
  parameter int CLUSTERS  = kcc_pkg::CLUSTERS_DEF,
  parameter int DIMENSION = kcc_pkg::DIMENSION_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  kcc_in_if.sink                          in_ch,
  kcc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [kcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kcc_pkg::CFG_W-1:0]       cfg_data
);
  // configuration registers
  logic [kcc_pkg::SHIFT_W-1:0] shift_threshold;
  logic [kcc_pkg::DIM_W-1:0]   dimension_in_use;

  kcc_pkg::cmd_t  cmd;
  kcc_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_threshold  <= kcc_pkg::THRESHOLD_RESET;
      dimension_in_use <= kcc_pkg::DIMENSION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kcc_pkg::REG_THRESHOLD: shift_threshold  <= cfg_data[kcc_pkg::SHIFT_W-1:0];
        kcc_pkg::REG_DIMENSION: dimension_in_use <= cfg_data[kcc_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: walks clusters and elements, issues at most one datapath operation a cycle
  kcc_controller #(
    .CLUSTERS  (CLUSTERS),
    .DIMENSION (DIMENSION)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_slot   (in_ch.slot_index),
    .cmd       (cmd),
    .stat      (stat)
  );

  // memories, accumulators, serial arithmetic and the output register
  kcc_datapath #(
    .CLUSTERS  (CLUSTERS),
    .DIMENSION (DIMENSION)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .threshold       (shift_threshold),
    .dim             (dimension_in_use),
    .in_action       (in_ch.action),
    .in_bits         (in_ch.point_bits),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cluster_id  (out_ch.cluster_id),
    .out_total_shift (out_ch.total_shift),
    .out_converged   (out_ch.converged)
  );

endmodule

/* tb/sv/kcc_cluster_checker.sv */
`timescale 1ns / 1ps
module kcc_cluster_checker (
  input  logic      clk,
  input  logic      rst,
  kcc_in_if         in_ch,
  kcc_out_if        out_ch,
  input  logic      cfg_we,
  input  logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcc_pkg::CFG_W-1:0]     cfg_data,
  output int        errors,
  output int        outstanding
);
  localparam int NC = kcc_pkg::CLUSTERS_DEF;
  localparam int ND = kcc_pkg::DIMENSION_DEF;

  typedef struct {
    logic [kcc_pkg::ID_W-1:0]    cluster_id;
    logic [kcc_pkg::SHIFT_W-1:0] total_shift;
    logic                        converged;
  } cluster_result_t;

  cluster_result_t result_fifo[$];

  logic [kcc_pkg::VAL_W-1:0]   centroid[NC][ND];
  logic [kcc_pkg::NORM_W-1:0]  norm_sq[NC];
  logic [kcc_pkg::VAL_W-1:0]   bit_sums[NC][ND];
  logic [kcc_pkg::VAL_W-1:0]   point_counts[NC];
  logic [kcc_pkg::SHIFT_W-1:0] threshold;
  logic [kcc_pkg::DIM_W-1:0]   dim_reg;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic refresh_norm(int c);
    logic [63:0] acc;
    acc = '0;
    for (int j = 0; j < ND; j++) acc += 64'(centroid[c][j]) * 64'(centroid[c][j]);
    norm_sq[c] = acc[kcc_pkg::NORM_W-1:0];
  endtask

  task automatic clear_accumulators();
    for (int c = 0; c < NC; c++) begin
      point_counts[c] = '0;
      for (int j = 0; j < ND; j++) bit_sums[c][j] = '0;
    end
  endtask

  function automatic int nearest_cluster(logic [63:0] bits);
    int best;
    bit have;
    logic [63:0] dot, best_dot, best_norm;
    logic [127:0] lhs, rhs;
    best = 0;
    have = 0;
    best_dot = '0;
    best_norm = '0;
    for (int c = 0; c < NC; c++) begin
      dot = '0;
      for (int j = 0; j < ND; j++) if (bits[j]) dot += 64'(centroid[c][j]);
      if (dot == 0 || norm_sq[c] == 0) continue;
      if (have) begin
        lhs = 128'(dot * dot) * 128'(best_norm);
        rhs = 128'(best_dot * best_dot) * 128'(norm_sq[c]);
        if (!(lhs > rhs)) continue;
      end
      have = 1;
      best = c;
      best_dot = dot;
      best_norm = 64'(norm_sq[c]);
    end
    return best;
  endfunction

  // recenter every non-empty cluster and return the saturated total move
  task automatic recenter(output logic [kcc_pkg::SHIFT_W-1:0] shift);
    logic [63:0] total, n, sq, nv, ov, d;
    total = '0;
    for (int c = 0; c < NC; c++) begin
      n = 64'(point_counts[c]);
      if (n == 0) continue;
      sq = '0;
      for (int j = 0; j < ND; j++) begin
        nv = (64'(bit_sums[c][j]) * 64'd65536 + n / 2) / n;
        if (nv > 64'd65536) nv = 64'd65536;
        ov = 64'(centroid[c][j]);
        d = nv > ov ? nv - ov : ov - nv;
        sq += d * d;
        centroid[c][j] = nv[kcc_pkg::VAL_W-1:0];
      end
      refresh_norm(c);
      total += int_sqrt(sq);
    end
    clear_accumulators();
    if (total > 64'(kcc_pkg::SHIFT_MAX)) total = 64'(kcc_pkg::SHIFT_MAX);
    shift = total[kcc_pkg::SHIFT_W-1:0];
  endtask

  task automatic predict_item(logic [kcc_pkg::ACTION_W-1:0] act,
                              logic [kcc_pkg::SLOT_W-1:0] slot,
                              logic [kcc_pkg::POINT_W-1:0] raw);
    cluster_result_t r;
    logic [63:0] mask, bits;
    int d, c;
    d = int'(dim_reg);
    if (d == 0) d = 1;
    if (d > ND) d = ND;
    mask = (d >= 64) ? '1 : ((64'd1 << d) - 64'd1);
    bits = raw & mask;
    r = '{cluster_id: 0, total_shift: 0, converged: 0};
    if (act == kcc_pkg::ACT_LOAD) begin
      if (int'(slot) < NC) begin
        for (int j = 0; j < ND; j++) centroid[slot][j] = bits[j] ? kcc_pkg::ONE_Q16 : '0;
        refresh_norm(int'(slot));
      end
    end else if (act == kcc_pkg::ACT_ASSIGN) begin
      c = nearest_cluster(bits);
      if (point_counts[c] < kcc_pkg::ACC_MAX) begin
        point_counts[c]++;
        for (int j = 0; j < ND; j++)
          if (bits[j] && bit_sums[c][j] < kcc_pkg::ACC_MAX) bit_sums[c][j]++;
      end
      r.cluster_id = c[kcc_pkg::ID_W-1:0];
    end else if (act == kcc_pkg::ACT_END) begin
      recenter(r.total_shift);
      r.converged = r.total_shift <= threshold;
    end
    result_fifo.insert(result_fifo.size(), r);
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    threshold = kcc_pkg::THRESHOLD_RESET;
    dim_reg = kcc_pkg::DIMENSION_RESET;
    for (int c = 0; c < NC; c++) begin
      norm_sq[c] = '0;
      for (int j = 0; j < ND; j++) centroid[c][j] = '0;
    end
    clear_accumulators();
  end

  always @(posedge clk) begin
    cluster_result_t e;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == kcc_pkg::REG_THRESHOLD)
          threshold = cfg_data[kcc_pkg::SHIFT_W-1:0];
        else if (cfg_index == kcc_pkg::REG_DIMENSION)
          dim_reg = cfg_data[kcc_pkg::DIM_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_fifo.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          e = result_fifo.pop_front();
          if (out_ch.cluster_id !== e.cluster_id) begin
            $error("cluster_id expected %0d actual %0d", e.cluster_id, out_ch.cluster_id);
            errors++;
          end
          if (out_ch.total_shift !== e.total_shift) begin
            $error("total_shift expected %0d actual %0d", e.total_shift, out_ch.total_shift);
            errors++;
          end
          if (out_ch.converged !== e.converged) begin
            $error("converged expected %0d actual %0d", e.converged, out_ch.converged);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.action, in_ch.slot_index, in_ch.point_bits);
    end
    outstanding <= result_fifo.size();
  end
endmodule

/* tb/sv/kmeans_cosine_cluster_engine_test.sv */
`timescale 1ns / 1ps
module kmeans_cosine_cluster_engine_test;
  // codes the package leaves unnamed
  localparam logic [kcc_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [kcc_pkg::SLOT_W-1:0]   SLOT_NONE   = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kcc_pkg::CFG_W-1:0]     cfg_data = '0;
  int errors;
  int outstanding;
  int rx_count = 0;
  bit quiet = 0;   // when set, neither side draws random idle gaps

  kcc_in_if  in_ch ();
  kcc_out_if out_ch ();

  kmeans_cosine_cluster_engine u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kcc_cluster_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  always #4 clk = ~clk;

  // safety net well beyond the slowest legal run
  initial begin
    #1_000_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // offer one transaction; valid stays high into the next one when there is no gap
  task automatic send_item(logic [kcc_pkg::ACTION_W-1:0] act,
                           logic [kcc_pkg::SLOT_W-1:0] slot,
                           logic [kcc_pkg::POINT_W-1:0] bits);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.slot_index <= slot;
    in_ch.point_bits <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait until every expected result is back, with the input lowered
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [kcc_pkg::CFG_IDX_W-1:0] idx,
                           logic [kcc_pkg::CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // dense, sparse, single-bit or uniform points so dot products and ties both show up
  function automatic logic [kcc_pkg::POINT_W-1:0] rand_point();
    logic [kcc_pkg::POINT_W-1:0] p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: p = p & {$urandom, $urandom};
      1: p = p | {$urandom, $urandom};
      2: p = 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return p;
  endfunction

  // receiver: random ready gaps, one long hold-off to back up the block
  initial begin
    int g;
    out_ch.ready = 0;
    forever begin
      g = idle_draw();
      if (rx_count == 300) g = 3000;
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      rx_count++;
    end
  end

  initial begin
    logic [kcc_pkg::CFG_W-1:0] thr;
    logic [kcc_pkg::DIM_W-1:0] dim;
    int n_assign;
    in_ch.valid = 0;
    in_ch.action = '0;
    in_ch.slot_index = '0;
    in_ch.point_bits = '0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, every action, empty and zero-similarity cases
    write_reg(kcc_pkg::REG_THRESHOLD, 21'd0);
    write_reg(kcc_pkg::REG_DIMENSION, 21'd64);
    send_item(kcc_pkg::ACT_ASSIGN, 2'd0, '1);   // all centroids zero -> cluster 0
    send_item(kcc_pkg::ACT_END, 2'd0, '0);      // only cluster 0 populated
    send_item(kcc_pkg::ACT_END, 2'd0, '0);      // every cluster empty
    send_item(kcc_pkg::ACT_LOAD, 2'd0, '1);
    send_item(kcc_pkg::ACT_LOAD, 2'd1, '1);     // tie with slot 0
    send_item(kcc_pkg::ACT_LOAD, 2'd2, 64'hFFFF_FFFF_0000_0000);
    send_item(kcc_pkg::ACT_LOAD, SLOT_NONE, 64'h5555_5555_5555_5555);
    send_item(ACT_UNKNOWN, SLOT_NONE, '1);
    send_item(kcc_pkg::ACT_ASSIGN, 2'd1, '1);   // tie, lowest index wins
    send_item(kcc_pkg::ACT_ASSIGN, 2'd2, '0);   // zero point
    send_item(kcc_pkg::ACT_ASSIGN, 2'd3, 64'hFFFF_FFFF_0000_0000);
    send_item(kcc_pkg::ACT_ASSIGN, 2'd0, 64'h8000_0000_0000_0001);
    send_item(kcc_pkg::ACT_ASSIGN, 2'd0, 64'h0000_0000_FFFF_FFFF);
    send_item(kcc_pkg::ACT_END, 2'd0, '1);
    send_item(kcc_pkg::ACT_LOAD, 2'd1, '0);     // zero centroid is never picked
    send_item(kcc_pkg::ACT_ASSIGN, 2'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(kcc_pkg::ACT_END, SLOT_NONE, '0);
    drain();
    write_reg(kcc_pkg::REG_THRESHOLD, 21'd2097151);
    write_reg(kcc_pkg::REG_DIMENSION, 21'd0);    // acts as one feature
    send_item(kcc_pkg::ACT_LOAD, 2'd0, '1);
    send_item(kcc_pkg::ACT_ASSIGN, 2'd0, '1);
    send_item(kcc_pkg::ACT_ASSIGN, 2'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(kcc_pkg::ACT_END, 2'd0, '0);
    drain();

    // random phases: reseed, assign a batch, end the pass
    for (int ph = 0; ph < 36; ph++) begin
      case (ph % 6)
        0: thr = 21'd0;
        1: thr = 21'd2097151;
        2: thr = kcc_pkg::THRESHOLD_RESET;
        default: thr = kcc_pkg::CFG_W'($urandom_range(0, 200000));
      endcase
      case (ph % 7)
        0: dim = 7'd1;
        1: dim = 7'd64;
        2: dim = 7'd127;
        3: dim = 7'd0;
        default: dim = kcc_pkg::DIM_W'($urandom_range(1, 127));
      endcase
      write_reg(kcc_pkg::REG_THRESHOLD, thr);
      write_reg(kcc_pkg::REG_DIMENSION, kcc_pkg::CFG_W'(dim));
      quiet = (ph % 5 == 3);
      for (int s = 0; s < 3; s++)
        if ($urandom_range(0, 9) != 0) send_item(kcc_pkg::ACT_LOAD, s[1:0], rand_point());
      n_assign = $urandom_range(20, 40);
      for (int k = 0; k < n_assign; k++) begin
        case ($urandom_range(0, 19))
          0: send_item(ACT_UNKNOWN, kcc_pkg::SLOT_W'($urandom), rand_point());
          1: send_item(kcc_pkg::ACT_LOAD, kcc_pkg::SLOT_W'($urandom), rand_point());
          2: send_item(kcc_pkg::ACT_END, kcc_pkg::SLOT_W'($urandom), rand_point());
          default: send_item(kcc_pkg::ACT_ASSIGN, kcc_pkg::SLOT_W'($urandom), rand_point());
        endcase
      end
      send_item(kcc_pkg::ACT_END, kcc_pkg::SLOT_W'($urandom), rand_point());
      if ($urandom_range(0, 3) == 0)
        send_item(kcc_pkg::ACT_END, kcc_pkg::SLOT_W'($urandom), rand_point());
      drain();
    end
    quiet = 0;

    repeat (200) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* kmeans_cosine_cluster_engine.f */
rtl/kcc_pkg.sv
rtl/kcc_in_if.sv
rtl/kcc_out_if.sv
rtl/kcc_datapath.sv
rtl/kcc_controller.sv
rtl/kmeans_cosine_cluster_engine.sv
tb/sv/kcc_cluster_checker.sv
tb/sv/kmeans_cosine_cluster_engine_test.sv
